// File: hw/rtl/hrlp_pkg.sv
`default_nettype none

package hrlp_pkg;

    // Default URL buffer size; URL_MAX-1 characters are passed out at most.
    localparam int URL_MAX_DEF = 256;

    // The only byte that counts as a field separator.
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Expected lengths and saturation values of the method and version counters.
    localparam logic [2:0] METHOD_LEN = 3'd3;
    localparam logic [2:0] METHOD_SAT = 3'd4;
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] VERSION_SAT = 4'd9;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [7:0] url_char;
        logic       is_verdict;
        logic       accepted;
        logic [7:0] url_length;
        logic       url_truncated;
    } res_t;

    // Folds ASCII lower-case letters to upper case.
    function automatic logic [7:0] fold_up(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // Characters of the method "GET".
    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h47;
            2'd1:    r = 8'h45;
            2'd2:    r = 8'h54;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Characters of "HTTP/1.1".
    function automatic logic [7:0] ver_a_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h48;
            3'd1:    r = 8'h54;
            3'd2:    r = 8'h54;
            3'd3:    r = 8'h50;
            3'd4:    r = 8'h2f;
            3'd5:    r = 8'h31;
            3'd6:    r = 8'h2e;
            default: r = 8'h31;
        endcase
        return r;
    endfunction

    // Characters of "HTTP/1.0".
    function automatic logic [7:0] ver_b_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd7:    r = 8'h30;
            default: r = ver_a_char(idx);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hrlp_parser.sv
`default_nettype none

module hrlp_parser
    import hrlp_pkg::*;
#(
    parameter int URL_MAX = URL_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            res_valid,
    output res_t            res
);

    localparam int UCW = $clog2(URL_MAX + 1);
    localparam int LW  = (UCW > 8) ? UCW : 8;
    localparam logic [UCW-1:0] URL_LIMIT = UCW'(URL_MAX - 1);
    localparam logic [UCW-1:0] URL_FULL  = UCW'(URL_MAX);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_METHOD,
        PH_SP1,
        PH_URL,
        PH_SP2,
        PH_VER,
        PH_TRAIL
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [2:0]     method_count_reg, method_count_next;
    logic           method_ok_reg, method_ok_next;
    logic [3:0]     version_count_reg, version_count_next;
    logic [1:0]     version_matches_reg, version_matches_next;
    logic [UCW-1:0] url_count_reg, url_count_next;
    logic           line_error_reg, line_error_next;

    logic           sp;
    logic           do_method;
    logic           do_version;
    logic           url_byte;
    logic [7:0]     up;
    logic           trunc;
    logic [UCW-1:0] len;
    logic [LW-1:0]  len_ext;
    logic           ok;

    assign sp = (in_byte == SPACE_CHAR);
    assign up = fold_up(in_byte);

    // Phase machine and field checks for the current byte.
    always_comb begin
        phase_next           = phase_reg;
        method_count_next    = method_count_reg;
        method_ok_next       = method_ok_reg;
        version_count_next   = version_count_reg;
        version_matches_next = version_matches_reg;
        url_count_next       = url_count_reg;
        line_error_next      = line_error_reg;
        do_method            = 1'b0;
        do_version           = 1'b0;
        url_byte             = 1'b0;
        res_valid            = 1'b0;
        res                  = '0;

        unique case (phase_reg)
            PH_LEAD: begin
                if (!sp) begin
                    phase_next = PH_METHOD;
                    do_method  = 1'b1;
                end
            end
            PH_METHOD: begin
                if (sp) begin
                    phase_next = PH_SP1;
                end else begin
                    do_method = 1'b1;
                end
            end
            PH_SP1: begin
                if (!sp) begin
                    phase_next = PH_URL;
                    url_byte   = 1'b1;
                end
            end
            PH_URL: begin
                if (sp) begin
                    phase_next = PH_SP2;
                end else begin
                    url_byte = 1'b1;
                end
            end
            PH_SP2: begin
                if (!sp) begin
                    phase_next = PH_VER;
                    do_version = 1'b1;
                end
            end
            PH_VER: begin
                if (sp) begin
                    phase_next = PH_TRAIL;
                end else begin
                    do_version = 1'b1;
                end
            end
            default: begin
                if (!sp) begin
                    line_error_next = 1'b1;
                end
            end
        endcase

        // Method comparison against "GET", saturating count.
        if (do_method) begin
            if (method_count_reg < METHOD_LEN) begin
                if (up != method_char(method_count_reg[1:0])) begin
                    method_ok_next = 1'b0;
                end
                method_count_next = method_count_reg + 3'd1;
            end else begin
                method_count_next = METHOD_SAT;
            end
        end

        // Version comparison against both accepted versions at once.
        if (do_version) begin
            if (version_count_reg < VERSION_LEN) begin
                if (up != ver_a_char(version_count_reg[2:0])) begin
                    version_matches_next[0] = 1'b0;
                end
                if (up != ver_b_char(version_count_reg[2:0])) begin
                    version_matches_next[1] = 1'b0;
                end
                version_count_next = version_count_reg + 4'd1;
            end else begin
                version_count_next = VERSION_SAT;
            end
        end

        // URL characters go out until the buffer limit, then truncation is marked.
        if (url_byte && !in_last) begin
            if (url_count_reg < URL_LIMIT) begin
                url_count_next = url_count_reg + UCW'(1);
                res_valid      = 1'b1;
                res.url_char   = in_byte;
            end else begin
                url_count_next = URL_FULL;
            end
        end

        // Accept decision, taken after the final byte has gone through the phase machine
        // and before the state returns to its reset values.
        ok = !line_error_next
             && (phase_next == PH_VER || phase_next == PH_TRAIL)
             && method_ok_next && (method_count_next == METHOD_LEN)
             && (version_count_next == VERSION_LEN)
             && (version_matches_next != 2'b00);

        // The final byte yields the verdict and returns all state to reset values.
        if (in_last) begin
            res_valid         = 1'b1;
            res.is_verdict    = 1'b1;
            res.accepted      = ok;
            res.url_length    = len_ext[7:0];
            res.url_truncated = trunc;

            phase_next           = PH_LEAD;
            method_count_next    = '0;
            method_ok_next       = 1'b1;
            version_count_next   = '0;
            version_matches_next = 2'b11;
            url_count_next       = '0;
            line_error_next      = 1'b0;
        end
    end

    // Verdict length terms; the final byte never changes the URL count.
    assign trunc   = (url_count_reg >= URL_FULL);
    assign len     = trunc ? URL_LIMIT : url_count_reg;
    assign len_ext = LW'(len);

    // Line state advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_LEAD;
            method_count_reg    <= '0;
            method_ok_reg       <= 1'b1;
            version_count_reg   <= '0;
            version_matches_reg <= 2'b11;
            url_count_reg       <= '0;
            line_error_reg      <= 1'b0;
        end else if (in_valid) begin
            phase_reg           <= phase_next;
            method_count_reg    <= method_count_next;
            method_ok_reg       <= method_ok_next;
            version_count_reg   <= version_count_next;
            version_matches_reg <= version_matches_next;
            url_count_reg       <= url_count_next;
            line_error_reg      <= line_error_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hrlp_out_buf.sv
`default_nettype none

module hrlp_out_buf
    import hrlp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      space_ok,
    output logic      out_valid,
    output res_t      out_data,
    input  wire logic out_ready
);

    logic main_valid_reg, main_valid_next;
    res_t main_data_reg, main_data_next;
    logic skid_valid_reg, skid_valid_next;
    res_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign space_ok  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Output register with a skid entry behind it, so a result can be taken in
    // while the previous one still waits for its transfer.
    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/http_request_line_parser_core.sv
`default_nettype none

// HTTP request line parser. The line enters one byte per transfer on the slave
// stream, with tlast on its final byte. Each URL byte comes out as its own
// transfer (tuser low), up to URL_MAX-1 of them; the final byte produces one
// verdict transfer (tuser high) with the accept flag, the URL length (low 8
// bits) and a truncation flag, after which the parser is ready for a new line.
// A line is accepted when the method is GET and the version HTTP/1.1 or
// HTTP/1.0, both compared without regard to letter case, and nothing but
// spaces follows the version. Throughput is one byte per clock: the phase
// machine and its compares are combinational between the byte and the result
// register, and a two-entry output buffer keeps input flowing while one result
// waits; input stalls only when both entries are full.

module http_request_line_parser_core
    import hrlp_pkg::*;
#(
    parameter int URL_MAX = URL_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // line_byte [7:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // url_char [7:0], accepted [8],
                                             // url_length [16:9], url_truncated [17]
    output logic             m_axis_tuser    // is_verdict
);

    logic in_xfer;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Phase machine, field checks and result formation.
    hrlp_parser #(
        .URL_MAX (URL_MAX)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_xfer),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register with skid entry.
    hrlp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_xfer && res_valid),
        .push_data (res),
        .space_ok  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .out_ready (m_axis_tready)
    );

    // Pack the result fields onto the master stream.
    assign m_axis_tdata = {6'd0, out_res.url_truncated, out_res.url_length,
                           out_res.accepted, out_res.url_char};
    assign m_axis_tuser = out_res.is_verdict;

endmodule

`default_nettype wire
